FILE: rtl/rrs_pkg.sv
package rrs_pkg;

	localparam int MAX_PROCESSES = 64;
	localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
	localparam int DATA_W = 16;
	localparam int TIME_W = 24;
	localparam int SUM_W = 30;
	localparam int NUM_W = 7;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [DATA_W-1:0] QUANTUM_RESET = DATA_W'(1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic REG_QUANTUM = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_READ,
		ST_RUN,
		ST_TAT,
		ST_SUM,
		ST_WSUM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic decide;
		logic run;
		logic tat;
		logic sum;
		logic wsum;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic have_pick;
		logic run_fin;
		logic slot_free;
	} dp_status_t;

endpackage

FILE: rtl/rrs_ctrl.sv
module rrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               opcode,
	output logic               in_stall,
	output rrs_pkg::dp_cmd_t   cmd,
	input  rrs_pkg::dp_status_t status
);
	import rrs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_STEP) begin
					state_d = status.count_zero ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = status.have_pick ? ST_READ : ST_EMIT;
			ST_READ:   state_d = ST_RUN;
			ST_RUN:    state_d = status.run_fin ? ST_TAT : ST_EMIT;
			ST_TAT:    state_d = ST_SUM;
			ST_SUM:    state_d = ST_WSUM;
			ST_WSUM:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = accept && opcode == OP_LOAD;
				cmd.scan_start = accept && opcode == OP_STEP;
			end
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_RUN:    cmd.run = 1'b1;
			ST_TAT:    cmd.tat = 1'b1;
			ST_SUM:    cmd.sum = 1'b1;
			ST_WSUM:   cmd.wsum = 1'b1;
			ST_EMIT:   cmd.emit = status.slot_free;
			default:   cmd = '0;
		endcase
	end

endmodule

FILE: rtl/rrs_dp.sv
module rrs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrs_pkg::dp_cmd_t              cmd,
	output rrs_pkg::dp_status_t           status,
	input  logic [rrs_pkg::DATA_W-1:0]    quantum,
	input  logic [rrs_pkg::DATA_W-1:0]    arrival,
	input  logic [rrs_pkg::DATA_W-1:0]    burst,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic                          slice_valid,
	output logic [rrs_pkg::TIME_W-1:0]    end_time,
	output logic [rrs_pkg::NUM_W-1:0]     process_number,
	output logic                          finished,
	output logic                          all_done,
	output logic [rrs_pkg::SUM_W-1:0]     turnaround_total,
	output logic [rrs_pkg::SUM_W-1:0]     waiting_total,
	output logic [rrs_pkg::NUM_W-1:0]     done_count
);
	import rrs_pkg::*;

	logic [DATA_W-1:0] arr_mem [MAX_PROCESSES];
	logic [DATA_W-1:0] bur_mem [MAX_PROCESSES];
	logic [DATA_W-1:0] rem_mem [MAX_PROCESSES];

	logic [DATA_W-1:0] rd_arr_q;
	logic [DATA_W-1:0] rd_bur_q;
	logic [DATA_W-1:0] rd_rem_q;
	logic [IDX_W-1:0]  rd_addr;

	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  pos_q;
	logic [TIME_W-1:0] time_q;
	logic [SUM_W-1:0]  turn_q;
	logic [SUM_W-1:0]  wait_q;
	logic [CNT_W-1:0]  done_q;

	logic [IDX_W-1:0]  scan_idx_q;
	logic              scan_vld_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic              hi_found_q;
	logic [IDX_W-1:0]  hi_idx_q;
	logic              lo_found_q;
	logic [IDX_W-1:0]  lo_idx_q;
	logic              pend_q;
	logic [DATA_W-1:0] min_arr_q;
	logic [IDX_W-1:0]  min_idx_q;

	logic [IDX_W-1:0]  pick_q;
	logic              sv_q;
	logic              fin_q;
	logic [TIME_W-1:0] tat_q;
	logic [TIME_W-1:0] wt_q;
	logic              out_valid_q;

	logic              load_ok;
	logic              elig;
	logic              pending;
	logic [DATA_W-1:0] q_eff;
	logic              run_fin;
	logic [DATA_W-1:0] run_len;
	logic [DATA_W-1:0] rem_next;
	logic [TIME_W:0]   time_sum;
	logic [TIME_W-1:0] time_run;
	logic [SUM_W:0]    turn_sum;
	logic [SUM_W:0]    wait_sum;
	logic [CNT_W-1:0]  pick_num;
	logic [IDX_W-1:0]  pos_next;
	logic              have_pick;
	logic [IDX_W-1:0]  pick_sel;

	assign load_ok = cmd.load && burst != '0 && count_q < CNT_W'(MAX_PROCESSES);
	assign rd_addr = cmd.scan_step ? scan_idx_q : pick_q;

	always_ff @(posedge clk) begin
		if (load_ok) begin
			arr_mem[count_q[IDX_W-1:0]] <= arrival;
			bur_mem[count_q[IDX_W-1:0]] <= burst;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			rem_mem[count_q[IDX_W-1:0]] <= burst;
		end else if (cmd.run) begin
			rem_mem[pick_q] <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		rd_arr_q <= arr_mem[rd_addr];
		rd_bur_q <= bur_mem[rd_addr];
		rd_rem_q <= rem_mem[rd_addr];
	end

	assign pending = rd_rem_q != '0;
	assign elig = pending && TIME_W'(rd_arr_q) <= time_q;

	assign q_eff = (quantum == '0) ? DATA_W'(1) : quantum;
	assign run_fin = rd_rem_q <= q_eff;
	assign run_len = run_fin ? rd_rem_q : q_eff;
	assign rem_next = rd_rem_q - run_len;
	assign time_sum = {1'b0, time_q} + (TIME_W + 1)'(run_len);
	assign time_run = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
	assign turn_sum = {1'b0, turn_q} + (SUM_W + 1)'(tat_q);
	assign wait_sum = {1'b0, wait_q} + (SUM_W + 1)'(wt_q);
	assign pick_num = CNT_W'(pick_q) + CNT_W'(1);
	assign pos_next = (pick_q == IDX_W'(MAX_PROCESSES - 1)) ? '0 : pick_q + IDX_W'(1);

	assign have_pick = hi_found_q || lo_found_q || pend_q;
	assign pick_sel = hi_found_q ? hi_idx_q : (lo_found_q ? lo_idx_q : min_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			scan_vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			scan_vld_s1 <= cmd.scan_step;
			idx_s1 <= scan_idx_q;
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_found_q <= 1'b0;
			hi_idx_q <= '0;
			lo_found_q <= 1'b0;
			lo_idx_q <= '0;
			pend_q <= 1'b0;
			min_arr_q <= '0;
			min_idx_q <= '0;
		end else if (cmd.scan_start) begin
			hi_found_q <= 1'b0;
			lo_found_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (scan_vld_s1) begin
			if (elig && !lo_found_q) begin
				lo_found_q <= 1'b1;
				lo_idx_q <= idx_s1;
			end
			if (elig && !hi_found_q && idx_s1 >= pos_q) begin
				hi_found_q <= 1'b1;
				hi_idx_q <= idx_s1;
			end
			if (pending && (!pend_q || rd_arr_q < min_arr_q)) begin
				pend_q <= 1'b1;
				min_arr_q <= rd_arr_q;
				min_idx_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q <= '0;
			time_q <= '0;
			turn_q <= '0;
			wait_q <= '0;
			done_q <= '0;
			pick_q <= '0;
			sv_q <= 1'b0;
			fin_q <= 1'b0;
			tat_q <= '0;
			wt_q <= '0;
		end else begin
			if (load_ok) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.decide) begin
				pick_q <= pick_sel;
				sv_q <= have_pick;
				fin_q <= 1'b0;
				if (!hi_found_q && !lo_found_q && pend_q && TIME_W'(min_arr_q) > time_q) begin
					time_q <= TIME_W'(min_arr_q);
				end
			end
			if (cmd.run) begin
				time_q <= time_run;
				fin_q <= run_fin;
				pos_q <= pos_next;
			end
			if (cmd.tat) begin
				tat_q <= time_q - TIME_W'(rd_arr_q);
			end
			if (cmd.sum) begin
				turn_q <= turn_sum[SUM_W] ? SUM_MAX : turn_sum[SUM_W-1:0];
				wt_q <= (tat_q > TIME_W'(rd_bur_q)) ? tat_q - TIME_W'(rd_bur_q) : '0;
				done_q <= done_q + CNT_W'(1);
			end
			if (cmd.wsum) begin
				wait_q <= wait_sum[SUM_W] ? SUM_MAX : wait_sum[SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			slice_valid <= sv_q;
			end_time <= time_q;
			process_number <= sv_q ? NUM_W'(pick_num) : '0;
			finished <= fin_q;
			all_done <= done_q == count_q;
			turnaround_total <= turn_q;
			waiting_total <= wait_q;
			done_count <= NUM_W'(done_q);
		end
	end

	assign out_valid = out_valid_q;

	assign status.count_zero = count_q == '0;
	assign status.scan_last = CNT_W'(scan_idx_q) == count_q - CNT_W'(1);
	assign status.have_pick = have_pick;
	assign status.run_fin = run_fin;
	assign status.slot_free = !out_valid_q || !out_stall;

	a_done_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= count_q)
		else $error("completed count exceeds loaded count");

	a_pos_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(pos_q) <= count_q)
		else $error("scan position beyond loaded entries");

	a_time_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> time_q >= $past(time_q))
		else $error("simulated time moved backward");

	a_fin_has_slice: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> sv_q)
		else $error("completion flagged without a slice");

endmodule

FILE: rtl/round_robin_scheduler_sim.sv
// Channel | Direction | Handshake            | Payload
// in      | in        | in_valid / in_stall  | opcode, arrival, burst
// out     | out       | out_valid / out_stall| slice_valid, end_time, process_number,
//         |           |                      | finished, all_done, turnaround_total,
//         |           |                      | waiting_total, done_count
// cfg     | in        | APB psel / penable   | quantum at byte address 0
//
// Load items may follow back to back.
// A step item runs a scan that reads the table memories one entry per cycle, then picks
// a pending entry, if any, reads it and runs it for up to one quantum; a completing
// process also adds to the turnaround and waiting totals. With an empty table the scan
// is skipped. in_stall stays high until the result is emitted, so no new item is taken.
// Reset: asynchronous arst_n clears counters, time, totals and quantum (to 1).
// A stalled output holds the result; the block then waits before the next result.
module round_robin_scheduler_sim (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rrs_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [rrs_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [rrs_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic [rrs_pkg::DATA_W-1:0]        arrival,
	input  logic [rrs_pkg::DATA_W-1:0]        burst,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              slice_valid,
	output logic [rrs_pkg::TIME_W-1:0]        end_time,
	output logic [rrs_pkg::NUM_W-1:0]         process_number,
	output logic                              finished,
	output logic                              all_done,
	output logic [rrs_pkg::SUM_W-1:0]         turnaround_total,
	output logic [rrs_pkg::SUM_W-1:0]         waiting_total,
	output logic [rrs_pkg::NUM_W-1:0]         done_count
);
	import rrs_pkg::*;

	logic [DATA_W-1:0] quantum_q;
	logic              cfg_wr;
	dp_cmd_t           cmd;
	dp_status_t        status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_wr && paddr[2] == REG_QUANTUM) begin
			quantum_q <= pwdata[DATA_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_QUANTUM) ? APB_DATA_W'(quantum_q) : '0;

	rrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	rrs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.quantum          (quantum_q),
		.arrival          (arrival),
		.burst            (burst),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.slice_valid      (slice_valid),
		.end_time         (end_time),
		.process_number   (process_number),
		.finished         (finished),
		.all_done         (all_done),
		.turnaround_total (turnaround_total),
		.waiting_total    (waiting_total),
		.done_count       (done_count)
	);

endmodule
